// ===== rtl/bts_pkg.sv =====
// Shared constants, types and register indexes for the barycentric triangle shader.
`default_nettype none
package bts_pkg;

    localparam int COORD_INT_BITS   = 12;
    localparam int COORD_W          = 16;
    localparam int COORD_FRAC_BITS  = COORD_W - COORD_INT_BITS;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int WEIGHT_W         = WEIGHT_FRAC_BITS + 1;

    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int AREA_W  = PROD_W + 1;
    localparam int MAG_W   = AREA_W - 1;
    localparam int QUOT_W  = WEIGHT_W;

    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 3 * CHAN_W;
    localparam int CPROD_W = CHAN_W + WEIGHT_W;
    localparam int CSUM_W  = CPROD_W + 2;
    localparam int CSHR_W  = CSUM_W - WEIGHT_FRAC_BITS;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = WEIGHT_W'(1) << WEIGHT_FRAC_BITS;
    localparam logic [WEIGHT_W-1:0] WEIGHT_THIRD = WEIGHT_ONE / 3;
    localparam logic [CSUM_W-1:0]   ROUND_HALF   = CSUM_W'(1) << (WEIGHT_FRAC_BITS - 1);
    localparam logic [CHAN_W-1:0]   CHAN_MAX     = {CHAN_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_A  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_B  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_C  = 3'd5;

    typedef struct packed {
        logic in_tri;
        logic flat;
    } side_t;

endpackage
`default_nettype wire

// ===== rtl/bts_div.sv =====
// Pipelined restoring divider: two rounded quotients over a shared divisor, one bit per stage.
`default_nettype none
module bts_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire bts_pkg::side_t               in_side,
    input  wire logic [bts_pkg::MAG_W-1:0]    num_b,
    input  wire logic [bts_pkg::MAG_W-1:0]    num_c,
    input  wire logic [bts_pkg::MAG_W-1:0]    den,
    output logic                              out_valid,
    output bts_pkg::side_t                    out_side,
    output logic [bts_pkg::QUOT_W-1:0]        quot_b,
    output logic [bts_pkg::QUOT_W-1:0]        quot_c
);

    localparam int MW    = bts_pkg::MAG_W;
    localparam int QW    = bts_pkg::QUOT_W;
    localparam int NUM_W = MW + QW;
    localparam int STEPS = QW;

    logic [NUM_W-1:0] dvd_b;
    logic [NUM_W-1:0] dvd_c;

    logic                 valid_reg [STEPS];
    bts_pkg::side_t       side_reg  [STEPS];
    logic [MW-1:0]        den_reg   [STEPS];
    logic [MW-1:0]        rb_reg    [STEPS];
    logic [MW-1:0]        rc_reg    [STEPS];
    logic [QW-1:0]        lob_reg   [STEPS];
    logic [QW-1:0]        loc_reg   [STEPS];

    // add half the divisor to round to nearest
    assign dvd_b = {1'b0, num_b, {bts_pkg::WEIGHT_FRAC_BITS{1'b0}}}
                 + NUM_W'(den >> 1);
    assign dvd_c = {1'b0, num_c, {bts_pkg::WEIGHT_FRAC_BITS{1'b0}}}
                 + NUM_W'(den >> 1);

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        logic           v_in;
        bts_pkg::side_t side_in;
        logic [MW-1:0]  den_in;
        logic [MW-1:0]  rb_in;
        logic [MW-1:0]  rc_in;
        logic [QW-1:0]  lob_in;
        logic [QW-1:0]  loc_in;
        logic [MW:0]    tb;
        logic [MW:0]    tc;
        logic [MW:0]    db;
        logic [MW:0]    dc;
        logic           geb;
        logic           gec;

        if (s == 0) begin : g_first
            assign v_in    = in_valid;
            assign side_in = in_side;
            assign den_in  = den;
            assign rb_in   = dvd_b[NUM_W-1:QW];
            assign rc_in   = dvd_c[NUM_W-1:QW];
            assign lob_in  = dvd_b[QW-1:0];
            assign loc_in  = dvd_c[QW-1:0];
        end
        else begin : g_next
            assign v_in    = valid_reg[s-1];
            assign side_in = side_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign rb_in   = rb_reg[s-1];
            assign rc_in   = rc_reg[s-1];
            assign lob_in  = lob_reg[s-1];
            assign loc_in  = loc_reg[s-1];
        end

        assign tb  = {rb_in, lob_in[QW-1]};
        assign tc  = {rc_in, loc_in[QW-1]};
        assign db  = tb - {1'b0, den_in};
        assign dc  = tc - {1'b0, den_in};
        assign geb = (tb >= {1'b0, den_in});
        assign gec = (tc >= {1'b0, den_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[s] <= side_in;
                den_reg[s]  <= den_in;
                rb_reg[s]   <= geb ? db[MW-1:0] : tb[MW-1:0];
                rc_reg[s]   <= gec ? dc[MW-1:0] : tc[MW-1:0];
                lob_reg[s]  <= {lob_in[QW-2:0], geb};
                loc_reg[s]  <= {loc_in[QW-2:0], gec};
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];
    assign quot_b    = lob_reg[STEPS-1];
    assign quot_c    = loc_reg[STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/barycentric_triangle_shade.sv =====
// A pixel passes the offset, product, magnitude, divider, weight, color-product and output registers in turn.
// Throughput: one pixel per cycle unless a result waits on out_ready; the 17-stage quotient pipeline sets the depth.
// The whole pipeline advances together; it holds only while a result waits on out_ready.
// Reset clears all valid bits and the configuration registers to zero.
// Top level: edge functions, area ratios, weight clamp and color blend.
`default_nettype none
module barycentric_triangle_shade (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [bts_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [bts_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [bts_pkg::COORD_INT_BITS-1:0]   pixel_x,
    input  wire logic [bts_pkg::COORD_INT_BITS-1:0]   pixel_y,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      inside_res,
    output logic [bts_pkg::CHAN_W-1:0]                red,
    output logic [bts_pkg::CHAN_W-1:0]                green,
    output logic [bts_pkg::CHAN_W-1:0]                blue,
    output logic [bts_pkg::WEIGHT_W-1:0]              weight_a,
    output logic [bts_pkg::WEIGHT_W-1:0]              weight_b,
    output logic [bts_pkg::WEIGHT_W-1:0]              weight_c
);

    localparam int CW  = bts_pkg::COORD_W;
    localparam int DW  = bts_pkg::DIFF_W;
    localparam int PW  = bts_pkg::PROD_W;
    localparam int AW  = bts_pkg::AREA_W;
    localparam int MW  = bts_pkg::MAG_W;
    localparam int WW  = bts_pkg::WEIGHT_W;
    localparam int HW  = bts_pkg::CHAN_W;
    localparam int KW  = bts_pkg::CPROD_W;
    localparam int SW  = bts_pkg::CSUM_W;
    localparam int RW  = bts_pkg::CSHR_W;

    logic en;

    logic [CW-1:0]              vx_reg    [3];
    logic [CW-1:0]              vy_reg    [3];
    logic [bts_pkg::COLOR_W-1:0] color_reg [3];

    logic [CW-1:0]              px;
    logic [CW-1:0]              py;

    logic                       v1_reg;
    logic signed [DW-1:0]       dx_reg [3];
    logic signed [DW-1:0]       dy_reg [3];
    logic signed [DW-1:0]       ebx_reg, eby_reg, ecx_reg, ecy_reg;

    logic                       v2_reg;
    logic signed [PW-1:0]       prod_reg [8];

    logic signed [AW-1:0]       area_a, area_b, area_c, area_t;
    logic signed [AW-1:0]       neg_b, neg_c, neg_t;
    logic [AW-1:0]              abs_b, abs_c, abs_t;
    bts_pkg::side_t             side_next;

    logic                       v3_reg;
    bts_pkg::side_t             side3_reg;
    logic [MW-1:0]              mag_b_reg, mag_c_reg, mag_t_reg;

    logic                       vd;
    bts_pkg::side_t             side_d;
    logic [bts_pkg::QUOT_W-1:0] quot_b, quot_c;

    logic signed [WW+1:0]       wc_full;
    logic [WW-1:0]              wa_next, wb_next, wc_next;

    logic                       vw_reg;
    logic                       inw_reg;
    logic [WW-1:0]              w_reg [3];

    logic                       vm_reg;
    logic                       inm_reg;
    logic [WW-1:0]              wm_reg [3];
    logic [KW-1:0]              cprod_reg [3][3];

    logic [SW-1:0]              csum  [3];
    logic [RW-1:0]              cshr  [3];
    logic [HW-1:0]              chan_next [3];

    logic                       out_valid_reg;
    logic                       inside_reg;
    logic [HW-1:0]              chan_reg [3];
    logic [WW-1:0]              wo_reg   [3];

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                vx_reg[k]    <= '0;
                vy_reg[k]    <= '0;
                color_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bts_pkg::REG_VERTEX_A:
                begin
                    vx_reg[0] <= cfg_data[2*CW-1:CW];
                    vy_reg[0] <= cfg_data[CW-1:0];
                end
                bts_pkg::REG_VERTEX_B:
                begin
                    vx_reg[1] <= cfg_data[2*CW-1:CW];
                    vy_reg[1] <= cfg_data[CW-1:0];
                end
                bts_pkg::REG_VERTEX_C:
                begin
                    vx_reg[2] <= cfg_data[2*CW-1:CW];
                    vy_reg[2] <= cfg_data[CW-1:0];
                end
                bts_pkg::REG_COLOR_A: color_reg[0] <= cfg_data[bts_pkg::COLOR_W-1:0];
                bts_pkg::REG_COLOR_B: color_reg[1] <= cfg_data[bts_pkg::COLOR_W-1:0];
                bts_pkg::REG_COLOR_C: color_reg[2] <= cfg_data[bts_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    assign px = {pixel_x, {bts_pkg::COORD_FRAC_BITS{1'b0}}};
    assign py = {pixel_y, {bts_pkg::COORD_FRAC_BITS{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            vw_reg        <= 1'b0;
            vm_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            vw_reg        <= vd;
            vm_reg        <= vw_reg;
            out_valid_reg <= vm_reg;
        end
    end

    // vertex offsets from the pixel and triangle edges from the first vertex
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dx_reg[k] <= $signed({1'b0, vx_reg[k]}) - $signed({1'b0, px});
                dy_reg[k] <= $signed({1'b0, vy_reg[k]}) - $signed({1'b0, py});
            end
            ebx_reg <= $signed({1'b0, vx_reg[1]}) - $signed({1'b0, vx_reg[0]});
            eby_reg <= $signed({1'b0, vy_reg[1]}) - $signed({1'b0, vy_reg[0]});
            ecx_reg <= $signed({1'b0, vx_reg[2]}) - $signed({1'b0, vx_reg[0]});
            ecy_reg <= $signed({1'b0, vy_reg[2]}) - $signed({1'b0, vy_reg[0]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= dx_reg[0] * dy_reg[1];
            prod_reg[1] <= dx_reg[1] * dy_reg[0];
            prod_reg[2] <= dx_reg[1] * dy_reg[2];
            prod_reg[3] <= dx_reg[2] * dy_reg[1];
            prod_reg[4] <= dx_reg[2] * dy_reg[0];
            prod_reg[5] <= dx_reg[0] * dy_reg[2];
            prod_reg[6] <= ebx_reg * ecy_reg;
            prod_reg[7] <= ecx_reg * eby_reg;
        end
    end

    assign area_a = $signed({prod_reg[0][PW-1], prod_reg[0]})
                  - $signed({prod_reg[1][PW-1], prod_reg[1]});
    assign area_b = $signed({prod_reg[2][PW-1], prod_reg[2]})
                  - $signed({prod_reg[3][PW-1], prod_reg[3]});
    assign area_c = $signed({prod_reg[4][PW-1], prod_reg[4]})
                  - $signed({prod_reg[5][PW-1], prod_reg[5]});
    assign area_t = $signed({prod_reg[6][PW-1], prod_reg[6]})
                  - $signed({prod_reg[7][PW-1], prod_reg[7]});

    assign neg_b = -area_b;
    assign neg_c = -area_c;
    assign neg_t = -area_t;
    assign abs_b = area_b[AW-1] ? neg_b : area_b;
    assign abs_c = area_c[AW-1] ? neg_c : area_c;
    assign abs_t = area_t[AW-1] ? neg_t : area_t;

    always_comb
    begin
        logic any_neg;
        logic any_pos;
        any_neg = area_a[AW-1] || area_b[AW-1] || area_c[AW-1];
        any_pos = (!area_a[AW-1] && (area_a != '0))
               || (!area_b[AW-1] && (area_b != '0))
               || (!area_c[AW-1] && (area_c != '0));
        side_next.in_tri = !(any_neg && any_pos);
        side_next.flat   = (area_t == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side3_reg <= side_next;
            mag_b_reg <= abs_b[MW-1:0];
            mag_c_reg <= abs_c[MW-1:0];
            mag_t_reg <= abs_t[MW-1:0];
        end
    end

    bts_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .in_side   (side3_reg),
        .num_b     (mag_b_reg),
        .num_c     (mag_c_reg),
        .den       (mag_t_reg),
        .out_valid (vd),
        .out_side  (side_d),
        .quot_b    (quot_b),
        .quot_c    (quot_c)
    );

    assign wc_full = $signed({2'b00, bts_pkg::WEIGHT_ONE})
                   - $signed({2'b00, quot_b})
                   - $signed({2'b00, quot_c});

    always_comb
    begin
        wa_next = (quot_b > bts_pkg::WEIGHT_ONE) ? bts_pkg::WEIGHT_ONE : quot_b;
        wb_next = (quot_c > bts_pkg::WEIGHT_ONE) ? bts_pkg::WEIGHT_ONE : quot_c;
        if (wc_full[WW+1])
        begin
            wc_next = '0;
        end
        else if (wc_full > $signed({2'b00, bts_pkg::WEIGHT_ONE}))
        begin
            wc_next = bts_pkg::WEIGHT_ONE;
        end
        else
        begin
            wc_next = wc_full[WW-1:0];
        end
        if (!side_d.in_tri)
        begin
            wa_next = '0;
            wb_next = '0;
            wc_next = '0;
        end
        else if (side_d.flat)
        begin
            wa_next = bts_pkg::WEIGHT_THIRD;
            wb_next = bts_pkg::WEIGHT_THIRD;
            wc_next = bts_pkg::WEIGHT_THIRD;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inw_reg  <= side_d.in_tri;
            w_reg[0] <= wa_next;
            w_reg[1] <= wb_next;
            w_reg[2] <= wc_next;
        end
    end

    // channel ch of vertex k times weight k; red sits in the top byte
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inm_reg <= inw_reg;
            for (int k = 0; k < 3; k++)
            begin
                wm_reg[k] <= w_reg[k];
                for (int ch = 0; ch < 3; ch++)
                begin
                    cprod_reg[ch][k] <= color_reg[k][(3-ch)*HW-1 -: HW] * w_reg[k];
                end
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            csum[ch] = SW'(cprod_reg[ch][0]) + SW'(cprod_reg[ch][1])
                     + SW'(cprod_reg[ch][2]) + bts_pkg::ROUND_HALF;
            cshr[ch] = csum[ch][SW-1:bts_pkg::WEIGHT_FRAC_BITS];
            chan_next[ch] = (cshr[ch] > RW'(bts_pkg::CHAN_MAX)) ? bts_pkg::CHAN_MAX
                                                                 : cshr[ch][HW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inside_reg <= inm_reg;
            for (int k = 0; k < 3; k++)
            begin
                chan_reg[k] <= chan_next[k];
                wo_reg[k]   <= wm_reg[k];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;
    assign red        = chan_reg[0];
    assign green      = chan_reg[1];
    assign blue       = chan_reg[2];
    assign weight_a   = wo_reg[0];
    assign weight_b   = wo_reg[1];
    assign weight_c   = wo_reg[2];

endmodule
`default_nettype wire

// ===== rtl/bts_checker.sv =====
// Port-level checker for the barycentric triangle shader and its bind.
`default_nettype none
module bts_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_ready,
    input  wire logic                                 out_valid,
    input  wire logic                                 out_ready,
    input  wire logic                                 inside_res,
    input  wire logic [bts_pkg::CHAN_W-1:0]           red,
    input  wire logic [bts_pkg::CHAN_W-1:0]           green,
    input  wire logic [bts_pkg::CHAN_W-1:0]           blue,
    input  wire logic [bts_pkg::WEIGHT_W-1:0]         weight_a,
    input  wire logic [bts_pkg::WEIGHT_W-1:0]         weight_b,
    input  wire logic [bts_pkg::WEIGHT_W-1:0]         weight_c
);

    outside_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !inside_res |-> red == '0 && green == '0 && blue == '0
            && weight_a == '0 && weight_b == '0 && weight_c == '0)
        else $error("outside pixel with nonzero color or weight");

    weights_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> weight_a <= bts_pkg::WEIGHT_ONE && weight_b <= bts_pkg::WEIGHT_ONE
            && weight_c <= bts_pkg::WEIGHT_ONE)
        else $error("weight above one");

    held_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
            && $stable(blue) && $stable(inside_res) && $stable(weight_a))
        else $error("stalled result changed");

    ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind barycentric_triangle_shade bts_checker u_bts_checker (.*);
`default_nettype wire

// ===== tb/barycentric_triangle_shade_tb.sv =====
// Barycentric triangle shader testbench: directed and random pixels checked against a local predictor.
`timescale 1ns / 1ps
`default_nettype none
module barycentric_triangle_shade_tb;

    localparam int LATENCY = 22;
    localparam int HOLD_CYCLES = 120;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic                         in_tri;
        logic [bts_pkg::CHAN_W-1:0]   r;
        logic [bts_pkg::CHAN_W-1:0]   g;
        logic [bts_pkg::CHAN_W-1:0]   b;
        logic [bts_pkg::WEIGHT_W-1:0] wa;
        logic [bts_pkg::WEIGHT_W-1:0] wb;
        logic [bts_pkg::WEIGHT_W-1:0] wc;
    } shade_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [bts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bts_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [bts_pkg::COORD_INT_BITS-1:0] pixel_x = '0;
    logic [bts_pkg::COORD_INT_BITS-1:0] pixel_y = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic inside_res;
    logic [bts_pkg::CHAN_W-1:0] red, green, blue;
    logic [bts_pkg::WEIGHT_W-1:0] weight_a, weight_b, weight_c;

    barycentric_triangle_shade i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .out_valid(out_valid),
        .out_ready(out_ready), .inside_res(inside_res), .red(red), .green(green),
        .blue(blue), .weight_a(weight_a), .weight_b(weight_b), .weight_c(weight_c)
    );

    always #2 clk = ~clk;

    logic [31:0] tri_vtx [3];
    logic [23:0] tri_col [3];
    shade_t pending_shades[$];
    int errors = 0;
    int sent = 0;
    int received = 0;
    int inside_seen = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic holding = 1'b0;
    event hold_go;
    longint cycles = 0;

    function automatic longint edge_area(longint ax, longint ay, longint bx, longint by,
                                         longint cx, longint cy);
        return (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
    endfunction

    function automatic longint area_ratio(longint n, longint d);
        longint un;
        longint ud;
        longint q;
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        q = ((un << bts_pkg::WEIGHT_FRAC_BITS) + (ud >> 1)) / ud;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic longint clamp_weight(longint w);
        if (w < 0)
        begin
            return 0;
        end
        if (w > longint'(bts_pkg::WEIGHT_ONE))
        begin
            return longint'(bts_pkg::WEIGHT_ONE);
        end
        return w;
    endfunction

    function automatic logic [7:0] blend(int sh, longint wa, longint wb, longint wc);
        longint s;
        s = longint'((tri_col[0] >> sh) & 8'hff) * wa + longint'((tri_col[1] >> sh) & 8'hff) * wb
            + longint'((tri_col[2] >> sh) & 8'hff) * wc;
        s = (s + (longint'(1) << (bts_pkg::WEIGHT_FRAC_BITS - 1))) >>> bts_pkg::WEIGHT_FRAC_BITS;
        return s > 255 ? 8'hff : s[7:0];
    endfunction

    function automatic shade_t shade_pixel(logic [11:0] px, logic [11:0] py);
        shade_t res;
        longint x, y, ax, ay, bx, by, cx, cy, ea, eb, ec, total, wa, wb, wc;
        res = '0;
        x = longint'(px) << bts_pkg::COORD_FRAC_BITS;
        y = longint'(py) << bts_pkg::COORD_FRAC_BITS;
        ax = longint'(tri_vtx[0][31:16]); ay = longint'(tri_vtx[0][15:0]);
        bx = longint'(tri_vtx[1][31:16]); by = longint'(tri_vtx[1][15:0]);
        cx = longint'(tri_vtx[2][31:16]); cy = longint'(tri_vtx[2][15:0]);
        ea = edge_area(x, y, ax, ay, bx, by);
        eb = edge_area(x, y, bx, by, cx, cy);
        ec = edge_area(x, y, cx, cy, ax, ay);
        if ((ea < 0 || eb < 0 || ec < 0) && (ea > 0 || eb > 0 || ec > 0))
        begin
            return res;
        end
        total = edge_area(ax, ay, bx, by, cx, cy);
        if (total == 0)
        begin
            wa = longint'(bts_pkg::WEIGHT_ONE) / 3;
            wb = wa;
            wc = wa;
        end
        else
        begin
            wa = area_ratio(eb, total);
            wb = area_ratio(ec, total);
            wc = longint'(bts_pkg::WEIGHT_ONE) - wa - wb;
            wa = clamp_weight(wa);
            wb = clamp_weight(wb);
            wc = clamp_weight(wc);
        end
        res.in_tri = 1'b1;
        res.r = blend(16, wa, wb, wc);
        res.g = blend(8, wa, wb, wc);
        res.b = blend(0, wa, wb, wc);
        res.wa = wa[bts_pkg::WEIGHT_W-1:0];
        res.wb = wb[bts_pkg::WEIGHT_W-1:0];
        res.wc = wc[bts_pkg::WEIGHT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s at result %0d: got %0d, expected %0d", what, received, got, want);
        errors++;
    endtask

    task automatic write_reg(logic [bts_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx <= bts_pkg::REG_VERTEX_C)
        begin
            tri_vtx[idx[1:0]] = value;
        end
        else if (idx <= bts_pkg::REG_COLOR_C)
        begin
            tri_col[2'(idx - bts_pkg::REG_COLOR_A)] = value[23:0];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_shades.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_triangle(logic [31:0] va, logic [31:0] vb, logic [31:0] vc,
                                logic [23:0] ca, logic [23:0] cb, logic [23:0] cc);
        drain();
        write_reg(bts_pkg::REG_VERTEX_A, va);
        write_reg(bts_pkg::REG_VERTEX_B, vb);
        write_reg(bts_pkg::REG_VERTEX_C, vc);
        write_reg(bts_pkg::REG_COLOR_A, {8'(ca >> 24), ca});
        write_reg(bts_pkg::REG_COLOR_B, {8'hff, cb});
        write_reg(bts_pkg::REG_COLOR_C, {8'h00, cc});
    endtask

    task automatic send_pixel(logic [11:0] px, logic [11:0] py);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_x <= px;
        pixel_y <= py;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pending_shades.push_back(shade_pixel(px, py));
        sent++;
    endtask

    function automatic logic [31:0] vtx(int x, int y);
        return {16'(x), 16'(y)};
    endfunction

    function automatic logic [31:0] rand_vtx(int span);
        int x0;
        int y0;
        x0 = $urandom_range(4095 - span);
        y0 = $urandom_range(4095 - span);
        return {16'((x0 + $urandom_range(span)) << 4 | $urandom_range(15)),
                16'((y0 + $urandom_range(span)) << 4 | $urandom_range(15))};
    endfunction

    task automatic test_directed();
        set_triangle(vtx(160, 160), vtx(1600, 160), vtx(160, 1600), 24'hff0000, 24'h00ff00,
                     24'h0000ff);
        send_pixel(10, 10);
        send_pixel(11, 10);
        send_pixel(100, 10);
        send_pixel(10, 100);
        send_pixel(55, 55);
        send_pixel(50, 60);
        send_pixel(9, 9);
        send_pixel(30, 30);
        send_pixel(4095, 4095);
        send_pixel(0, 0);
        set_triangle(vtx(0, 0), vtx(65535, 0), vtx(0, 65535), 24'hffffff, 24'hffffff,
                     24'hffffff);
        send_pixel(0, 0);
        send_pixel(4095, 0);
        send_pixel(0, 4095);
        send_pixel(2047, 2048);
        send_pixel(4095, 4095);
        set_triangle(vtx(160, 160), vtx(320, 320), vtx(480, 480), 24'h123456, 24'habcdef,
                     24'h808080);
        send_pixel(15, 15);
        send_pixel(10, 10);
        send_pixel(40, 40);
        send_pixel(15, 16);
        set_triangle(vtx(320, 320), vtx(320, 320), vtx(320, 320), 24'hff00ff, 24'h00ff00,
                     24'hffffff);
        send_pixel(20, 20);
        send_pixel(21, 20);
        set_triangle(32'hffffffff, 32'hfff00000, 32'h0000fff0, 24'hffffff, 24'h000000,
                     24'h7f7f7f);
        send_pixel(4095, 4095);
        send_pixel(2048, 2048);
        send_pixel(4000, 100);
    endtask

    task automatic test_random(int n);
        int span;
        int lo_x, hi_x, lo_y, hi_y;
        for (int i = 0; i < n; i++)
        begin
            if (i % 60 == 0)
            begin
                span = ($urandom_range(7) == 0) ? 4095 : $urandom_range(200, 1);
                set_triangle(rand_vtx(span), rand_vtx(span), rand_vtx(span),
                             24'($urandom), 24'($urandom), 24'($urandom));
            end
            lo_x = int'(tri_vtx[0][31:20]);
            lo_y = int'(tri_vtx[0][15:4]);
            hi_x = lo_x;
            hi_y = lo_y;
            for (int k = 1; k < 3; k++)
            begin
                if (int'(tri_vtx[k][31:20]) < lo_x) lo_x = int'(tri_vtx[k][31:20]);
                if (int'(tri_vtx[k][31:20]) > hi_x) hi_x = int'(tri_vtx[k][31:20]);
                if (int'(tri_vtx[k][15:4]) < lo_y) lo_y = int'(tri_vtx[k][15:4]);
                if (int'(tri_vtx[k][15:4]) > hi_y) hi_y = int'(tri_vtx[k][15:4]);
            end
            if ($urandom_range(9) < 8)
            begin
                send_pixel(12'($urandom_range(hi_x + 1, lo_x)), 12'($urandom_range(hi_y + 1, lo_y)));
            end
            else
            begin
                send_pixel(12'($urandom), 12'($urandom));
            end
        end
    endtask

    task automatic test_backpressure();
        set_triangle(vtx(0, 0), vtx(4000, 0), vtx(0, 4000), 24'h00ff80, 24'h8000ff, 24'hff8000);
        -> hold_go;
        for (int i = 0; i < 60; i++)
        begin
            send_pixel(12'($urandom_range(200)), 12'($urandom_range(200)));
        end
        drain();
        for (int i = 0; i < 10; i++)
        begin
            send_pixel(12'($urandom_range(250)), 12'($urandom_range(250)));
        end
    endtask

    // hold the receiver off for a long stretch
    always
    begin
        @(hold_go);
        @(posedge clk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (holding)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_shades.size() == 0)
            begin
                $display("unexpected result with nothing pending");
                errors++;
            end
            else
            begin
                shade_t want;
                want = pending_shades.pop_front();
                if (inside_res !== want.in_tri) report_mismatch("inside_res", inside_res, want.in_tri);
                if (red !== want.r) report_mismatch("red", red, want.r);
                if (green !== want.g) report_mismatch("green", green, want.g);
                if (blue !== want.b) report_mismatch("blue", blue, want.b);
                if (weight_a !== want.wa) report_mismatch("weight_a", weight_a, want.wa);
                if (weight_b !== want.wb) report_mismatch("weight_b", weight_b, want.wb);
                if (weight_c !== want.wc) report_mismatch("weight_c", weight_c, want.wc);
                if (want.in_tri) inside_seen++;
            end
            received++;
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        for (int k = 0; k < 3; k++)
        begin
            tri_vtx[k] = '0;
            tri_col[k] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(220);
        send_idle_pct = 53; recv_stall_pct = 0;  test_random(220);
        send_idle_pct = 0;  recv_stall_pct = 53; test_random(220);
        send_idle_pct = 37; recv_stall_pct = 37; test_random(220);
        send_idle_pct = 0;  recv_stall_pct = 0;  test_backpressure();
        drain();
        $display("covered %0d pixels (%0d inside) over directed, random and stall phases",
                 sent, inside_seen);
        if (errors == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
`default_nettype wire
